/* rtl/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int USED_ENTRIES = 64;
    localparam int OFFSET_BITS  = 24;
    localparam int HDR_BITS     = 8;
    localparam int CNT_W        = 7;
    localparam int UIDX_W       = 6;
    localparam int BLK_W        = OFFSET_BITS + 2;
    localparam int SPLIT_SLACK  = 3;

    localparam logic [OFFSET_BITS-1:0] HEAP_SIZE_RST = 24'd65536;
    localparam logic [OFFSET_BITS-1:0] HEAP_BASE_RST = 24'd16;
    localparam logic [HDR_BITS-1:0]    HEADER_RST    = 8'd8;

    localparam logic [1:0] CFG_HEAP_SIZE = 2'd0;
    localparam logic [1:0] CFG_HEAP_BASE = 2'd1;
    localparam logic [1:0] CFG_HEADER    = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC  = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] last;
    } t_ext;

    typedef enum logic [2:0] {
        F_NONE,
        F_INIT,
        F_SET_START,
        F_SET_END,
        F_MERGE,
        F_INSERT
    } t_fop;

    typedef enum logic [1:0] {
        U_NONE,
        U_LOAD,
        U_SHIFT
    } t_uop;

    typedef struct packed {
        t_fop                   op;
        logic [CNT_W-1:0]       pos;
        logic [OFFSET_BITS-1:0] s;
        logic [OFFSET_BITS-1:0] e;
    } t_fcmd;

    typedef struct packed {
        t_uop                   op;
        logic [CNT_W-1:0]       pos;
        logic [OFFSET_BITS-1:0] s;
        logic [OFFSET_BITS-1:0] e;
    } t_ucmd;

endpackage
`default_nettype wire

/* rtl/ffa_req_if.sv */
`default_nettype none
interface ffa_req_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [ffa_pkg::OFFSET_BITS-1:0]    request_size;
    logic [ffa_pkg::OFFSET_BITS-1:0]    free_offset;

    modport source (output valid, operation, request_size, free_offset, input ready);
    modport sink   (input valid, operation, request_size, free_offset, output ready);
endinterface
`default_nettype wire

/* rtl/ffa_rsp_if.sv */
`default_nettype none
interface ffa_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ffa_pkg::OFFSET_BITS-1:0]    block_offset;
    logic [ffa_pkg::OFFSET_BITS-1:0]    freed_size;
    logic [1:0]                         status;
    logic                               gc_advised;

    modport source (output valid, block_offset, freed_size, status, gc_advised, input ready);
    modport sink   (input valid, block_offset, freed_size, status, gc_advised, output ready);
endinterface
`default_nettype wire

/* rtl/ffa_free_cell.sv */
`default_nettype none
module ffa_free_cell (
    input  wire logic                               i_clk,
    input  wire logic [ffa_pkg::CNT_W-1:0]          i_index,
    input  wire ffa_pkg::t_fcmd                     i_cmd,
    input  wire ffa_pkg::t_ext                      i_left,
    input  wire ffa_pkg::t_ext                      i_right,
    input  wire logic [ffa_pkg::BLK_W-1:0]          i_blk,
    input  wire logic [ffa_pkg::OFFSET_BITS-1:0]    i_key_end,
    output ffa_pkg::t_ext                           o_ext,
    output logic                                    o_fit,
    output logic                                    o_lt
);
    ffa_pkg::t_ext                        r_ext;
    logic [ffa_pkg::OFFSET_BITS:0]        w_len;

    assign o_ext = r_ext;
    assign w_len = {1'b0, r_ext.last} - {1'b0, r_ext.start} + 1'b1;
    assign o_fit = (r_ext.last >= r_ext.start) &&
                   ({1'b0, w_len} > (i_blk + ffa_pkg::BLK_W'(ffa_pkg::SPLIT_SLACK)));
    assign o_lt  = i_key_end < r_ext.start;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ffa_pkg::F_INIT: begin
                if (i_index == '0) begin
                    r_ext.start <= i_cmd.s;
                    r_ext.last  <= i_cmd.e;
                end
            end
            ffa_pkg::F_SET_START: begin
                if (i_index == i_cmd.pos) r_ext.start <= i_cmd.s;
            end
            ffa_pkg::F_SET_END: begin
                if (i_index == i_cmd.pos) r_ext.last <= i_cmd.e;
            end
            ffa_pkg::F_MERGE: begin
                // left neighbor absorbs the successor, the rest moves down
                if (i_index + 1'b1 == i_cmd.pos) r_ext.last <= i_right.last;
                else if (i_index >= i_cmd.pos) r_ext <= i_right;
            end
            ffa_pkg::F_INSERT: begin
                if (i_index == i_cmd.pos) begin
                    r_ext.start <= i_cmd.s;
                    r_ext.last  <= i_cmd.e;
                end else if (i_index > i_cmd.pos) begin
                    r_ext <= i_left;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/ffa_used_cell.sv */
`default_nettype none
module ffa_used_cell (
    input  wire logic                               i_clk,
    input  wire logic [ffa_pkg::CNT_W-1:0]          i_index,
    input  wire ffa_pkg::t_ucmd                     i_cmd,
    input  wire ffa_pkg::t_ext                      i_right,
    input  wire logic [ffa_pkg::OFFSET_BITS-1:0]    i_key,
    output ffa_pkg::t_ext                           o_ext,
    output logic                                    o_hit
);
    ffa_pkg::t_ext r_ext;

    assign o_ext = r_ext;
    assign o_hit = r_ext.start == i_key;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ffa_pkg::U_LOAD: begin
                if (i_index == i_cmd.pos) begin
                    r_ext.start <= i_cmd.s;
                    r_ext.last  <= i_cmd.e;
                end
            end
            ffa_pkg::U_SHIFT: begin
                if (i_index >= i_cmd.pos) r_ext <= i_right;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/first_fit_extent_allocator.sv */
`default_nettype none
// First-fit heap extent allocator. Free and allocated extents live in two rows
// of cells; every cell compares its own entry against a broadcast key, and an
// update shifts entries between neighbors in the apply step. An allocate goes
// from accept to result through query free row, pick first fit, apply; a free
// goes through query allocated row, pick, query free row, pick, apply. The
// next request is accepted once the apply step is done, while the previous
// result may still wait in the output register. After reset or any register
// write the block loads the initial free extent before it accepts a request.
module first_fit_extent_allocator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [ffa_pkg::OFFSET_BITS-1:0]    i_cfg_data,
    ffa_req_if.sink                                 i_req,
    ffa_rsp_if.source                               o_rsp
);
    localparam int NF = ffa_pkg::FREE_ENTRIES;
    localparam int NU = ffa_pkg::USED_ENTRIES;
    localparam int OB = ffa_pkg::OFFSET_BITS;
    localparam int CW = ffa_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_QUSED, S_SUSED, S_QFREE, S_SFREE, S_APPLY
    } t_state;

    t_state                         r_state;
    logic                           r_op;
    logic [OB-1:0]                  r_size, r_boff;
    logic [OB-1:0]                  r_heap_size, r_heap_base;
    logic [ffa_pkg::HDR_BITS-1:0]   r_hdr;
    logic [NF-1:0]                  r_fflag;
    logic [NU-1:0]                  r_uflag;
    logic                           r_ufound, r_ffound;
    logic [ffa_pkg::UIDX_W-1:0]     r_upos;
    logic [CW-1:0]                  r_fpos, r_fc, r_uc;
    logic [OB-1:0]                  r_s, r_e, r_start_at, r_end_prev;
    logic [OB-1:0]                  r_avail;
    logic                           r_latch;
    logic                           r_ov, r_gc;
    logic [OB-1:0]                  r_offset, r_freed;
    logic [1:0]                     r_status;

    ffa_pkg::t_fcmd                 w_fcmd;
    ffa_pkg::t_ucmd                 w_ucmd;
    ffa_pkg::t_ext                  w_fext [NF];
    ffa_pkg::t_ext                  w_uext [NU];
    logic [NF-1:0]                  w_fit, w_lt, w_fvalid;
    logic [NU-1:0]                  w_hit, w_uvalid;
    logic [ffa_pkg::BLK_W-1:0]      w_blk;
    logic                           w_out_free;

    assign w_blk      = {2'b00, r_size} + ffa_pkg::BLK_W'(r_hdr);
    assign w_out_free = !r_ov || o_rsp.ready;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.block_offset = r_offset;
    assign o_rsp.freed_size   = r_freed;
    assign o_rsp.status       = r_status;
    assign o_rsp.gc_advised   = r_gc;

    for (genvar j = 0; j < NF; j++) begin : g_free
        ffa_free_cell u_cell (
            .i_clk     (i_clk),
            .i_index   (CW'(j)),
            .i_cmd     (w_fcmd),
            .i_left    (w_fext[(j == 0) ? 0 : j - 1]),
            .i_right   (w_fext[(j == NF - 1) ? j : j + 1]),
            .i_blk     (w_blk),
            .i_key_end (r_e),
            .o_ext     (w_fext[j]),
            .o_fit     (w_fit[j]),
            .o_lt      (w_lt[j])
        );
        assign w_fvalid[j] = CW'(j) < r_fc;
    end

    for (genvar j = 0; j < NU; j++) begin : g_used
        ffa_used_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CW'(j)),
            .i_cmd   (w_ucmd),
            .i_right (w_uext[(j == NU - 1) ? j : j + 1]),
            .i_key   (r_boff),
            .o_ext   (w_uext[j]),
            .o_hit   (w_hit[j])
        );
        assign w_uvalid[j] = CW'(j) < r_uc;
    end

    // lowest set flag of each row
    logic [NU-1:0]                  w_uhot;
    logic [NF-1:0]                  w_fhot, w_at, w_prev;
    logic [ffa_pkg::UIDX_W-1:0]     w_upos;
    logic [CW-1:0]                  w_fenc;
    logic [OB-1:0]                  w_us, w_ue, w_start_at, w_end_prev;
    logic                           w_ffound;

    assign w_uhot   = r_uflag & (~r_uflag + NU'(1));
    assign w_fhot   = r_fflag & (~r_fflag + NF'(1));
    assign w_ffound = |r_fflag;

    always_comb begin
        w_upos = '0;
        w_us   = '0;
        w_ue   = '0;
        for (int j = 0; j < NU; j++) begin
            if (w_uhot[j]) begin
                w_upos = w_upos | ffa_pkg::UIDX_W'(j);
                w_us   = w_us | w_uext[j].start;
                w_ue   = w_ue | w_uext[j].last;
            end
        end
    end

    always_comb begin
        w_fenc = '0;
        for (int j = 0; j < NF; j++) begin
            if (w_fhot[j]) w_fenc = w_fenc | CW'(j);
            w_at[j] = w_ffound ? w_fhot[j] : (CW'(j) == r_fc);
        end
        for (int j = 0; j < NF - 1; j++) w_prev[j] = w_at[j + 1];
        w_prev[NF-1] = !w_ffound && (r_fc == CW'(NF));
        w_start_at = '0;
        w_end_prev = '0;
        for (int j = 0; j < NF; j++) begin
            if (w_at[j])   w_start_at = w_start_at | w_fext[j].start;
            if (w_prev[j]) w_end_prev = w_end_prev | w_fext[j].last;
        end
    end

    // apply-cycle decisions
    logic [OB-1:0]  w_len, w_cut;
    logic           w_back, w_front, w_stress, w_init_ok;

    assign w_len     = r_e - r_s + 1'b1;
    assign w_cut     = r_start_at + w_blk[OB-1:0];
    assign w_back    = r_ffound && ({1'b0, r_e} + 1'b1 == {1'b0, r_start_at});
    assign w_front   = (r_fpos != '0) && ({1'b0, r_end_prev} + 1'b1 == {1'b0, r_s});
    assign w_stress  = ({r_avail, 1'b0} < {1'b0, r_heap_size}) || (r_uc > CW'(NU / 2));
    assign w_init_ok = r_heap_base < r_heap_size;

    always_comb begin
        w_fcmd = '{op: ffa_pkg::F_NONE, pos: r_fpos, s: r_s, e: r_e};
        w_ucmd = '{op: ffa_pkg::U_NONE, pos: CW'(r_upos), s: r_start_at,
                   e: w_cut - 1'b1};
        if (r_state == S_INIT) begin
            w_fcmd.op = ffa_pkg::F_INIT;
            w_fcmd.s  = r_heap_base;
            w_fcmd.e  = r_heap_size - 1'b1;
        end else if (r_state == S_APPLY && w_out_free) begin
            if (r_op == ffa_pkg::OP_ALLOC) begin
                if (r_uc < CW'(NU) && r_ffound) begin
                    w_fcmd.op  = ffa_pkg::F_SET_START;
                    w_fcmd.s   = w_cut;
                    w_ucmd.op  = ffa_pkg::U_LOAD;
                    w_ucmd.pos = r_uc;
                end
            end else if (r_ufound) begin
                if (w_front && w_back) begin
                    w_fcmd.op = ffa_pkg::F_MERGE;
                end else if (w_front) begin
                    w_fcmd.op  = ffa_pkg::F_SET_END;
                    w_fcmd.pos = r_fpos - 1'b1;
                end else if (w_back) begin
                    w_fcmd.op = ffa_pkg::F_SET_START;
                end else if (r_fc < CW'(NF)) begin
                    w_fcmd.op = ffa_pkg::F_INSERT;
                end
                if (w_front || w_back || r_fc < CW'(NF)) w_ucmd.op = ffa_pkg::U_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_heap_size <= ffa_pkg::HEAP_SIZE_RST;
            r_heap_base <= ffa_pkg::HEAP_BASE_RST;
            r_hdr       <= ffa_pkg::HEADER_RST;
            r_ov        <= 1'b0;
            r_fc        <= '0;
            r_uc        <= '0;
            r_latch     <= 1'b0;
            r_avail     <= '0;
        end else begin
            if (r_ov && o_rsp.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_fc    <= w_init_ok ? CW'(1) : '0;
                    r_avail <= w_init_ok ? r_heap_size - r_heap_base : '0;
                    r_uc    <= '0;
                    r_latch <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.operation;
                        r_size  <= i_req.request_size;
                        r_boff  <= i_req.free_offset;
                        r_state <= (i_req.operation == ffa_pkg::OP_FREE) ? S_QUSED : S_QFREE;
                    end
                end
                S_QUSED: begin
                    r_uflag <= w_hit & w_uvalid;
                    r_state <= S_SUSED;
                end
                S_SUSED: begin
                    r_ufound <= |r_uflag;
                    r_upos   <= w_upos;
                    r_s      <= w_us;
                    r_e      <= w_ue;
                    r_state  <= S_QFREE;
                end
                S_QFREE: begin
                    r_fflag <= ((r_op == ffa_pkg::OP_FREE) ? w_lt : w_fit) & w_fvalid;
                    r_state <= S_SFREE;
                end
                S_SFREE: begin
                    r_ffound   <= w_ffound;
                    r_fpos     <= w_ffound ? w_fenc : r_fc;
                    r_start_at <= w_start_at;
                    r_end_prev <= w_end_prev;
                    r_state    <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_out_free) begin
                        r_ov     <= 1'b1;
                        r_offset <= '0;
                        r_freed  <= '0;
                        r_status <= ffa_pkg::ST_OK;
                        r_gc     <= r_latch;
                        r_state  <= S_IDLE;
                        if (r_op == ffa_pkg::OP_ALLOC) begin
                            if (r_uc >= CW'(NU)) begin
                                r_status <= ffa_pkg::ST_TABLE_FULL;
                                r_latch  <= r_latch | w_stress;
                                r_gc     <= r_latch | w_stress;
                            end else if (r_ffound) begin
                                r_offset <= r_start_at;
                                r_uc     <= r_uc + 1'b1;
                                r_avail  <= ({2'b00, r_avail} <= w_blk) ? '0 :
                                            r_avail - w_blk[OB-1:0];
                                r_latch  <= r_latch | w_stress;
                                r_gc     <= r_latch | w_stress;
                            end else begin
                                r_status <= ffa_pkg::ST_NO_FIT;
                                r_latch  <= 1'b1;
                                r_gc     <= 1'b1;
                            end
                        end else if (!r_ufound) begin
                            r_status <= ffa_pkg::ST_NOT_ALLOC;
                        end else if (!w_front && !w_back && r_fc >= CW'(NF)) begin
                            r_status <= ffa_pkg::ST_TABLE_FULL;
                        end else begin
                            r_freed <= w_len;
                            r_avail <= r_avail + w_len;
                            r_uc    <= r_uc - 1'b1;
                            if (w_front && w_back) r_fc <= r_fc - 1'b1;
                            else if (!w_front && !w_back) r_fc <= r_fc + 1'b1;
                        end
                    end
                end
                default: r_state <= S_INIT;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffa_pkg::CFG_HEAP_SIZE: begin
                        r_heap_size <= i_cfg_data;
                        r_state     <= S_INIT;
                    end
                    ffa_pkg::CFG_HEAP_BASE: begin
                        r_heap_base <= i_cfg_data;
                        r_state     <= S_INIT;
                    end
                    ffa_pkg::CFG_HEADER: begin
                        r_hdr   <= i_cfg_data[ffa_pkg::HDR_BITS-1:0];
                        r_state <= S_INIT;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/ffa_checker.sv */
`default_nettype none
module ffa_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_req_valid,
    input wire logic                               i_req_ready,
    input wire logic                               i_rsp_valid,
    input wire logic                               i_rsp_ready,
    input wire logic [ffa_pkg::OFFSET_BITS-1:0]    i_block_offset,
    input wire logic [ffa_pkg::OFFSET_BITS-1:0]    i_freed_size,
    input wire logic [1:0]                         i_status,
    input wire logic                               i_gc_advised
);
    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_block_offset) &&
        $stable(i_freed_size) && $stable(i_status) && $stable(i_gc_advised))
        else $error("result beat changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ffa_pkg::ST_OK |->
        i_block_offset == '0 && i_freed_size == '0)
        else $error("failed request carries nonzero size or offset");

    a_nofit_gc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ffa_pkg::ST_NO_FIT |-> i_gc_advised)
        else $error("no-fit result without advisory");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one still in work");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && !i_req_ready)
        else $error("handshake active right after reset");
endmodule

bind first_fit_extent_allocator ffa_checker u_ffa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_block_offset (o_rsp.block_offset),
    .i_freed_size   (o_rsp.freed_size),
    .i_status       (o_rsp.status),
    .i_gc_advised   (o_rsp.gc_advised)
);
`default_nettype wire
